// ===== design/atapio_pkg.sv =====
// Shared types and constants for the ATA PIO task file device.
package atapio_pkg;

  localparam int unsigned WORD_BITS = 16;

  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_IDENT = 8'hEC;

  localparam logic [2:0] OFF_DATA   = 3'd0;
  localparam logic [2:0] OFF_ERROR  = 3'd1;
  localparam logic [2:0] OFF_COUNT  = 3'd2;
  localparam logic [2:0] OFF_LBA_LO = 3'd3;
  localparam logic [2:0] OFF_LBA_MD = 3'd4;
  localparam logic [2:0] OFF_LBA_HI = 3'd5;
  localparam logic [2:0] OFF_DRVHD  = 3'd6;
  localparam logic [2:0] OFF_STATUS = 3'd7;

  localparam logic [0:0] CFG_DRIVE_PRESENT = 1'b0;
  localparam logic [0:0] CFG_REPORTED      = 1'b1;

  localparam logic [7:0] DRVHD_RESET = 8'hA0;

  typedef struct packed {
    logic        kind;
    logic [2:0]  reg_offset;
    logic [15:0] write_data;
  } access_t;

endpackage

// ===== design/atapio_front.sv =====
// Input queue that accepts bus accesses and holds them for the execution part.
module atapio_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  atapio_pkg::access_t  in_item,
  output logic                 valid,
  input  logic                 take,
  output atapio_pkg::access_t  item
);
  import atapio_pkg::*;

  access_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr <= ~wr_ptr;
      if (take && valid) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push && !full} - {1'b0, take && valid};
    end
  end
endmodule

// ===== design/atapio_back.sv =====
// Task file registers, command execution and the sector memory.
module atapio_back #(
  parameter int unsigned STORE_SECTORS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                drive_present,
  input  logic [10:0]         reported_sectors,
  input  logic                valid,
  output logic                take,
  input  atapio_pkg::access_t item,
  output logic                empty,
  input  logic                pop,
  output logic [15:0]         read_data
);
  import atapio_pkg::*;

  localparam int unsigned SEC_BITS   = (STORE_SECTORS > 1) ? $clog2(STORE_SECTORS) : 1;
  localparam int unsigned ADDR_BITS  = SEC_BITS + 8;
  localparam int unsigned STORE_WORDS = STORE_SECTORS * 256;
  localparam logic [28:0] STORE_LIM  = 29'(STORE_SECTORS);

  typedef enum logic [3:0] {
    M_IDLE  = 4'b0001,
    M_READ  = 4'b0010,
    M_WRITE = 4'b0100,
    M_IDENT = 4'b1000
  } mode_t;

  typedef enum logic [1:0] {
    R_REG = 2'b01,
    R_MEM = 2'b10
  } rsel_t;

  logic [15:0] mem [STORE_WORDS];

  logic [7:0]  count_reg, lba_low_reg, lba_mid_reg, lba_high_reg, drive_head_reg;
  logic        error_flag;
  mode_t       mode;
  logic [27:0] current_sector;
  logic [8:0]  sectors_left;
  logic [7:0]  word_index;

  // Result register: one held result, either a direct value or memory data.
  logic        res_valid;
  rsel_t       res_sel;
  logic [15:0] res_reg;
  logic [15:0] mem_q;

  logic        selected;
  logic [28:0] limit;
  logic [28:0] lba;
  logic [8:0]  nsec;
  logic [ADDR_BITS-1:0] addr;
  logic        fire;
  logic [7:0]  b;
  logic [15:0] r;
  logic        advance;
  logic        mem_rd;

  assign empty     = !res_valid;
  assign read_data = (res_sel == R_MEM) ? mem_q : res_reg;
  assign take      = valid && (!res_valid || pop);
  assign fire      = take;
  assign b         = item.write_data[7:0];
  assign selected  = drive_present && !drive_head_reg[4];
  assign limit     = ({18'd0, reported_sectors} < STORE_LIM) ?
                     {18'd0, reported_sectors} : STORE_LIM;
  assign lba       = {1'b0, drive_head_reg[3:0], lba_high_reg, lba_mid_reg, lba_low_reg};
  assign nsec      = (count_reg == 8'd0) ? 9'd256 : {1'b0, count_reg};
  // Out-of-store sectors map to word zero, as the range check never passes them.
  assign addr      = ({1'b0, current_sector} < STORE_LIM) ?
                     {current_sector[SEC_BITS-1:0], word_index} : '0;

  always_comb begin
    r       = 16'd0;
    advance = 1'b0;
    mem_rd  = 1'b0;
    if (item.kind) begin
      advance = (item.reg_offset == OFF_DATA) && selected && (mode == M_WRITE);
    end else begin
      unique case (item.reg_offset)
        OFF_DATA: begin
          if (selected && mode == M_READ) begin
            mem_rd  = 1'b1;
            advance = 1'b1;
          end else if (selected && mode == M_IDENT) begin
            advance = 1'b1;
            if (word_index == 8'd60) r = limit[15:0];
            else if (word_index == 8'd61) r = {3'd0, limit[28:16]};
          end
        end
        OFF_ERROR:  r = (selected && error_flag) ? 16'h0004 : 16'd0;
        OFF_COUNT:  r = {8'd0, count_reg};
        OFF_LBA_LO: r = {8'd0, lba_low_reg};
        OFF_LBA_MD: r = {8'd0, lba_mid_reg};
        OFF_LBA_HI: r = {8'd0, lba_high_reg};
        OFF_DRVHD:  r = {8'd0, drive_head_reg};
        default:    r = selected ?
                        {8'd0, 4'h4, (mode != M_IDLE), 2'b00, error_flag} : 16'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && mem_rd) mem_q <= mem[addr];
    if (fire && advance && item.kind) mem[addr] <= item.write_data;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_reg <= r;
      res_sel <= mem_rd ? R_MEM : R_REG;
    end
    if (rst) begin
      res_valid      <= 1'b0;
      res_sel        <= R_REG;
      count_reg      <= 8'd0;
      lba_low_reg    <= 8'd0;
      lba_mid_reg    <= 8'd0;
      lba_high_reg   <= 8'd0;
      drive_head_reg <= DRVHD_RESET;
      error_flag     <= 1'b0;
      mode           <= M_IDLE;
      current_sector <= 28'd0;
      sectors_left   <= 9'd0;
      word_index     <= 8'd0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      if (fire) begin
        res_valid <= 1'b1;
        if (advance) begin
          word_index <= word_index + 8'd1;
          if (word_index == 8'hFF) begin
            if (mode == M_IDENT) begin
              mode <= M_IDLE;
            end else begin
              current_sector <= current_sector + 28'd1;
              sectors_left   <= sectors_left - 9'd1;
              if (sectors_left <= 9'd1) mode <= M_IDLE;
            end
          end
        end
        if (item.kind) begin
          unique case (item.reg_offset)
            OFF_COUNT:  count_reg      <= b;
            OFF_LBA_LO: lba_low_reg    <= b;
            OFF_LBA_MD: lba_mid_reg    <= b;
            OFF_LBA_HI: lba_high_reg   <= b;
            OFF_DRVHD:  drive_head_reg <= b;
            OFF_STATUS: begin
              if (selected) begin
                error_flag   <= 1'b0;
                mode         <= M_IDLE;
                word_index   <= 8'd0;
                sectors_left <= 9'd0;
                if (b == CMD_READ || b == CMD_WRITE) begin
                  if (lba + {20'd0, nsec} > limit) begin
                    error_flag <= 1'b1;
                  end else begin
                    current_sector <= lba[27:0];
                    sectors_left   <= nsec;
                    mode           <= (b == CMD_READ) ? M_READ : M_WRITE;
                  end
                end else if (b == CMD_IDENT) begin
                  mode <= M_IDENT;
                end else begin
                  error_flag <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end
endmodule

// ===== design/ata_pio_task_file_device.sv =====
// Top level of the ATA PIO task file device: input queue, executor, config registers.
// Path: an access is held in the input queue, then executed into the result register,
// from which it is popped; a result that is not yet popped stalls the input queue.
// Throughput: one access per cycle sustained while each result is popped;
// execution is bounded by one single-port sector memory read or write per data access.
// Reset (rst, synchronous, active high) empties both queues and restores the task file;
// the sector memory is not cleared and holds undefined data until written.
module ata_pio_task_file_device #(
  parameter int unsigned STORE_SECTORS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [2:0]  reg_offset,
  input  logic [15:0] write_data,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import atapio_pkg::*;

  logic        drive_present;
  logic [10:0] reported_sectors;
  access_t     in_item;
  access_t     q_item;
  logic        q_valid;
  logic        q_take;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_present    <= 1'b1;
      reported_sectors <= 11'd1024;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DRIVE_PRESENT: drive_present    <= cfg_data[0];
        CFG_REPORTED:      reported_sectors <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{kind: kind, reg_offset: reg_offset, write_data: write_data};

  // The front queue decouples the bus from the executor so either side can stall.
  atapio_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .valid(q_valid), .take(q_take), .item(q_item)
  );

  atapio_back #(.STORE_SECTORS(STORE_SECTORS)) u_back (
    .clk(clk), .rst(rst), .drive_present(drive_present),
    .reported_sectors(reported_sectors), .valid(q_valid), .take(q_take),
    .item(q_item), .empty(empty), .pop(pop), .read_data(read_data)
  );
endmodule
